// File: rtl/wpsd_pkg.sv
package wpsd_pkg;

  typedef enum logic [5:0] {
    PH_RIFF = 6'b000001,
    PH_HDR  = 6'b000010,
    PH_FMT  = 6'b000100,
    PH_SKIP = 6'b001000,
    PH_DATA = 6'b010000,
    PH_DONE = 6'b100000
  } phase_t;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_ERROR  = 1'b1;

  localparam logic [31:0] TAG_FMT  = 32'h666D7420;
  localparam logic [31:0] TAG_DATA = 32'h64617461;

  localparam logic [31:0] RIFF_HDR_BYTES = 32'd12;
  localparam logic [31:0] FMT_USED_BYTES = 32'd16;

  localparam logic [2:0] HDR_LAST_BYTE = 3'd7;

  localparam logic [15:0] BITS_8  = 16'd8;
  localparam logic [15:0] BITS_16 = 16'd16;
  localparam logic [15:0] BITS_24 = 16'd24;
  localparam logic [15:0] BITS_32 = 16'd32;

  typedef struct packed {
    logic        kind;
    logic [15:0] ch;
    logic        last;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
  } res_meta_t;

  // Position of the sign bit for a sample of (wsel + 1) bytes.
  function automatic logic [4:0] sign_pos(input logic [1:0] wsel);
    sign_pos = {wsel, 3'b111};
  endfunction

  // Full-scale divisor 2^(bits-1) - 1 for a sample of (wsel + 1) bytes.
  function automatic logic [31:0] full_scale(input logic [1:0] wsel);
    full_scale = (32'd1 << sign_pos(wsel)) - 32'd1;
  endfunction

endpackage

// File: rtl/wav_pcm_stream_decoder_top.sv
// Byte-stream WAV decoder. One file byte is taken per clock cycle, with no gaps, as long as
// the result side keeps up; the parser updates its chunk state in the cycle a byte is taken.
// A completed PCM sample, or the single error result for an unsupported format, passes the
// parser register, then the register after the reciprocal multiplier that replaces the
// division by the full-scale value, and then the output register after the exact remainder
// correction, rounding and clamping. Samples are produced in Q2.30 by
// default (OUT_FRAC_BITS sets the fraction width), and only complete frames inside the data
// chunk produce results; bytes after the data chunk are dropped until file_start marks the
// first byte of a new file.
module wav_pcm_stream_decoder_top
  import wpsd_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               file_start,
  output logic               result_valid,
  input  logic               result_stall,
  output logic               kind,
  output logic signed [31:0] sample_value,
  output logic [15:0]        channel_index,
  output logic               last_sample,
  output logic [15:0]        channel_count,
  output logic [31:0]        rate_hz,
  output logic [15:0]        sample_bits
);

  localparam logic [30:0] RECIP0 = 31'((64'd1 << (OUT_FRAC_BITS + 7)) / 64'd127);
  localparam logic [30:0] RECIP1 = 31'((64'd1 << (OUT_FRAC_BITS + 15)) / 64'd32767);
  localparam logic [30:0] RECIP2 = 31'((64'd1 << (OUT_FRAC_BITS + 23)) / 64'd8388607);
  localparam logic [30:0] RECIP3 = 31'((64'd1 << (OUT_FRAC_BITS + 31)) / 64'd2147483647);
  localparam logic [31:0] UNITY  = 32'd1 << OUT_FRAC_BITS;

  // Parser state.
  phase_t      phase, phase_next;
  logic [31:0] phase_byte_count, count_next;
  logic [31:0] tag_name, tag_next;
  logic [31:0] tag_length, len_next;
  logic [15:0] channels_reg, chans_next;
  logic [31:0] rate_reg, rate_next;
  logic [15:0] bits_reg, bits_next;
  logic [31:0] data_bytes_left, left_next;
  logic [23:0] sample_accum, accum_next;
  logic [1:0]  byte_in_sample, bis_next;
  logic [15:0] channel_counter, ch_next;

  logic        accept;
  logic        emit;
  res_meta_t   emit_meta;

  logic        fmt_ok;
  logic [17:0] frame_bytes;
  logic [2:0]  hdr_pos;
  logic [31:0] hdr_tag;
  logic [31:0] hdr_len;
  logic [31:0] count_inc;
  logic [31:0] left_dec;
  logic [1:0]  nb_m1;
  logic [31:0] raw;
  logic        frame_end;
  logic signed [32:0] sval;
  logic [32:0] mag_full;

  // Pipeline registers.
  logic        s1_valid;
  res_meta_t   s1_meta;
  logic        s1_neg;
  logic [31:0] s1_mag;
  logic [1:0]  s1_wsel;

  logic        s2_valid;
  res_meta_t   s2_meta;
  logic        s2_neg;
  logic        s2_sat;
  logic [31:0] s2_mag;
  logic [31:0] s2_qe;
  logic [1:0]  s2_wsel;

  logic        out_free, s2_free, s1_free;

  logic [30:0] recip;
  logic [61:0] prod;
  logic [61:0] prod_sh;
  logic [32:0] rem;
  logic [33:0] rem2;
  logic [33:0] div_x1;
  logic [33:0] div_x3;
  logic [1:0]  round_inc;
  logic [31:0] q;
  logic [31:0] q_final;

  assign out_free   = !result_valid || !result_stall;
  assign s2_free    = !s2_valid || out_free;
  assign s1_free    = !s1_valid || s2_free;
  assign byte_stall = !s1_free;
  assign accept     = byte_valid && s1_free;

  assign fmt_ok = (bits_reg == BITS_8 || bits_reg == BITS_16 || bits_reg == BITS_24 ||
                   bits_reg == BITS_32) && (channels_reg != 16'd0);

  always_comb begin
    case (bits_reg[5:3])
      3'd1:    frame_bytes = {2'b00, channels_reg};
      3'd2:    frame_bytes = {1'b0, channels_reg, 1'b0};
      3'd3:    frame_bytes = {2'b00, channels_reg} + {1'b0, channels_reg, 1'b0};
      3'd4:    frame_bytes = {channels_reg, 2'b00};
      default: frame_bytes = 18'd0;
    endcase
  end

  assign hdr_pos   = phase_byte_count[2:0];
  assign hdr_tag   = (hdr_pos[2] == 1'b0) ? {tag_name[23:0], data_byte} : tag_name;
  assign hdr_len   = hdr_pos[2] ? (tag_length | (32'(data_byte) << {hdr_pos[1:0], 3'b000}))
                                : tag_length;
  assign count_inc = phase_byte_count + 32'd1;
  assign left_dec  = data_bytes_left - 32'd1;
  assign nb_m1     = 2'(bits_reg[5:3] - 3'd1);
  assign raw       = {8'd0, sample_accum} | (32'(data_byte) << {byte_in_sample, 3'b000});
  assign frame_end = ({1'b0, channel_counter} + 17'd1) >= {1'b0, channels_reg};

  always_comb begin
    case (nb_m1)
      2'd0:    sval = {{25{~raw[7]}}, ~raw[7], raw[6:0]};
      2'd1:    sval = {{17{raw[15]}}, raw[15:0]};
      2'd2:    sval = {{9{raw[23]}}, raw[23:0]};
      default: sval = {raw[31], raw};
    endcase
  end

  assign mag_full = sval[32] ? (33'd0 - sval) : sval;

  always_comb begin
    phase_next = phase;
    count_next = phase_byte_count;
    tag_next   = tag_name;
    len_next   = tag_length;
    chans_next = channels_reg;
    rate_next  = rate_reg;
    bits_next  = bits_reg;
    left_next  = data_bytes_left;
    accum_next = sample_accum;
    bis_next   = byte_in_sample;
    ch_next    = channel_counter;
    emit       = 1'b0;
    emit_meta.kind  = KIND_SAMPLE;
    emit_meta.ch    = channel_counter;
    emit_meta.last  = 1'b0;
    emit_meta.chans = channels_reg;
    emit_meta.rate  = rate_reg;
    emit_meta.bits  = bits_reg;

    if (file_start) begin
      // The first byte of a new file is also the first RIFF header byte.
      phase_next = PH_RIFF;
      count_next = 32'd1;
      tag_next   = 32'd0;
      len_next   = 32'd0;
      chans_next = 16'd0;
      rate_next  = 32'd0;
      bits_next  = 16'd0;
      left_next  = 32'd0;
      accum_next = 24'd0;
      bis_next   = 2'd0;
      ch_next    = 16'd0;
    end else begin
      case (phase)
        PH_RIFF: begin
          count_next = count_inc;
          if (count_inc >= RIFF_HDR_BYTES) begin
            phase_next = PH_HDR;
            count_next = 32'd0;
            tag_next   = 32'd0;
            len_next   = 32'd0;
          end
        end
        PH_HDR: begin
          tag_next   = hdr_tag;
          len_next   = hdr_len;
          count_next = 32'(hdr_pos) + 32'd1;
          if (hdr_pos == HDR_LAST_BYTE) begin
            count_next = 32'd0;
            if (hdr_tag == TAG_DATA) begin
              if (!fmt_ok) begin
                phase_next     = PH_DONE;
                emit           = 1'b1;
                emit_meta.kind = KIND_ERROR;
                emit_meta.ch   = 16'd0;
              end else begin
                left_next  = hdr_len;
                accum_next = 24'd0;
                bis_next   = 2'd0;
                ch_next    = 16'd0;
                phase_next = (hdr_len >= 32'(frame_bytes)) ? PH_DATA : PH_DONE;
              end
            end else if (hdr_len != 32'd0) begin
              phase_next = (hdr_tag == TAG_FMT) ? PH_FMT : PH_SKIP;
            end else begin
              tag_next = 32'd0;
              len_next = 32'd0;
            end
          end
        end
        PH_FMT, PH_SKIP: begin
          if (phase == PH_FMT && phase_byte_count < FMT_USED_BYTES) begin
            case (phase_byte_count[3:0])
              4'd2:    chans_next = {channels_reg[15:8], data_byte};
              4'd3:    chans_next = {data_byte, channels_reg[7:0]};
              4'd4:    rate_next  = {rate_reg[31:8], data_byte};
              4'd5:    rate_next  = {rate_reg[31:16], data_byte, rate_reg[7:0]};
              4'd6:    rate_next  = {rate_reg[31:24], data_byte, rate_reg[15:0]};
              4'd7:    rate_next  = {data_byte, rate_reg[23:0]};
              4'd14:   bits_next  = {bits_reg[15:8], data_byte};
              4'd15:   bits_next  = {data_byte, bits_reg[7:0]};
              default: chans_next = channels_reg;
            endcase
          end
          count_next = count_inc;
          if (count_inc == tag_length) begin
            phase_next = PH_HDR;
            count_next = 32'd0;
            tag_next   = 32'd0;
            len_next   = 32'd0;
          end
        end
        PH_DATA: begin
          left_next = left_dec;
          if (byte_in_sample != nb_m1) begin
            accum_next = raw[23:0];
            bis_next   = byte_in_sample + 2'd1;
          end else begin
            // A frame end with less than one frame left marks the final sample.
            emit           = 1'b1;
            emit_meta.last = frame_end && (left_dec < 32'(frame_bytes));
            ch_next        = frame_end ? 16'd0 : channel_counter + 16'd1;
            accum_next     = 24'd0;
            bis_next       = 2'd0;
            if (emit_meta.last) begin
              phase_next = PH_DONE;
            end
          end
        end
        default: begin
          phase_next = phase;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_RIFF;
      phase_byte_count <= 32'd0;
      tag_name         <= 32'd0;
      tag_length       <= 32'd0;
      channels_reg     <= 16'd0;
      rate_reg         <= 32'd0;
      bits_reg         <= 16'd0;
      data_bytes_left  <= 32'd0;
      sample_accum     <= 24'd0;
      byte_in_sample   <= 2'd0;
      channel_counter  <= 16'd0;
    end else if (accept) begin
      phase            <= phase_next;
      phase_byte_count <= count_next;
      tag_name         <= tag_next;
      tag_length       <= len_next;
      channels_reg     <= chans_next;
      rate_reg         <= rate_next;
      bits_reg         <= bits_next;
      data_bytes_left  <= left_next;
      sample_accum     <= accum_next;
      byte_in_sample   <= bis_next;
      channel_counter  <= ch_next;
    end
  end

  // Stage 1: sign and magnitude of the assembled sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_free) begin
      s1_valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free && accept && emit) begin
      s1_meta <= emit_meta;
      s1_neg  <= mag_full[32] ? 1'b0 : sval[32];
      s1_mag  <= mag_full[31:0];
      s1_wsel <= nb_m1;
    end
  end

  // Stage 2: quotient estimate by multiplying with the scaled reciprocal.
  always_comb begin
    case (s1_wsel)
      2'd0:    recip = RECIP0;
      2'd1:    recip = RECIP1;
      2'd2:    recip = RECIP2;
      default: recip = RECIP3;
    endcase
  end

  assign prod    = s1_mag[30:0] * recip;
  assign prod_sh = prod >> sign_pos(s1_wsel);

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_valid) begin
      s2_meta <= s1_meta;
      s2_neg  <= s1_neg;
      s2_sat  <= s1_mag >= full_scale(s1_wsel);
      s2_mag  <= s1_mag;
      s2_qe   <= prod_sh[31:0];
      s2_wsel <= s1_wsel;
    end
  end

  // Stage 3: the estimate is at most one below the true quotient; compares of the remainder fix
  // that and give round-to-nearest in the same two compares.
  assign rem = (33'(s2_mag) << OUT_FRAC_BITS) - (33'(s2_qe) << sign_pos(s2_wsel))
             + 33'(s2_qe);
  assign rem2   = {rem, 1'b0};
  assign div_x1 = 34'(full_scale(s2_wsel));
  assign div_x3 = div_x1 + {div_x1[32:0], 1'b0};
  assign round_inc = 2'(rem2 >= div_x1) + 2'(rem2 >= div_x3);
  assign q       = s2_sat ? UNITY : (s2_qe + 32'(round_inc));
  assign q_final = s2_neg ? (32'd0 - q) : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      kind          <= s2_meta.kind;
      sample_value  <= (s2_meta.kind == KIND_ERROR) ? 32'sd0 : $signed(q_final);
      channel_index <= s2_meta.ch;
      last_sample   <= s2_meta.last;
      channel_count <= s2_meta.chans;
      rate_hz       <= s2_meta.rate;
      sample_bits   <= s2_meta.bits;
    end
  end

endmodule

// File: dv/wav_pcm_stream_decoder_checker.sv
module wav_pcm_stream_decoder_checker
  import wpsd_pkg::*;
#(
  parameter int OUT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               byte_stall,
  input  logic [7:0]         data_byte,
  input  logic               file_start,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic               kind,
  input  logic signed [31:0] sample_value,
  input  logic [15:0]        channel_index,
  input  logic               last_sample,
  input  logic [15:0]        channel_count,
  input  logic [31:0]        rate_hz,
  input  logic [15:0]        sample_bits,
  output int                 fail_count,
  output int                 pending_count,
  output int                 sample_count,
  output int                 error_count
);

  typedef struct packed {
    logic        kind;
    logic [31:0] value;
    logic [15:0] ch;
    logic        last;
    logic [15:0] chans;
    logic [31:0] rate;
    logic [15:0] bits;
  } wav_result_t;

  wav_result_t expected_results[$];

  phase_t      phase;
  logic [31:0] phase_count;
  logic [31:0] tag;
  logic [31:0] tag_len;
  logic [15:0] fmt_chans;
  logic [31:0] fmt_rate;
  logic [15:0] fmt_bits;
  logic [31:0] bytes_left;
  logic [31:0] sample_word;
  logic [1:0]  byte_pos;
  logic [15:0] chan_pos;

  int fails = 0;
  int samples_seen = 0;
  int errors_seen = 0;

  task automatic clear_state();
    phase = PH_RIFF;
    phase_count = '0;
    tag = '0;
    tag_len = '0;
    fmt_chans = '0;
    fmt_rate = '0;
    fmt_bits = '0;
    bytes_left = '0;
    sample_word = '0;
    byte_pos = '0;
    chan_pos = '0;
  endtask

  task automatic enter_header();
    phase = PH_HDR;
    phase_count = '0;
    tag = '0;
    tag_len = '0;
  endtask

  function automatic wav_result_t make_result(input logic k, input logic [31:0] value,
                                              input logic [15:0] ch, input logic last);
    wav_result_t res;
    res.kind = k;
    res.value = value;
    res.ch = ch;
    res.last = last;
    res.chans = fmt_chans;
    res.rate = fmt_rate;
    res.bits = fmt_bits;
    return res;
  endfunction

  // Sample divided by the full-scale value, rounded half away from zero and clamped to one.
  function automatic logic [31:0] scale_sample(input logic [31:0] raw, input logic [2:0] nbytes);
    logic [63:0]        sign_bit;
    logic [63:0]        divisor;
    logic [63:0]        mag;
    logic [63:0]        quot;
    logic [63:0]        limit;
    logic signed [63:0] v;
    logic               neg;
    sign_bit = 64'd1 << (8 * nbytes - 1);
    divisor = sign_bit - 64'd1;
    if (nbytes == 3'd1) begin
      v = $signed({56'd0, raw[7:0]}) - 64'sd128;
    end else begin
      v = $signed(({32'd0, raw} & ((sign_bit << 1) - 64'd1)) ^ sign_bit) - $signed(sign_bit);
    end
    neg = v < 64'sd0;
    mag = neg ? -v : v;
    quot = (2 * (mag << OUT_FRAC_BITS) + divisor) / (2 * divisor);
    limit = 64'd1 << OUT_FRAC_BITS;
    if (quot > limit) quot = limit;
    return neg ? 32'd0 - quot[31:0] : quot[31:0];
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic fs);
    logic [2:0]  c3;
    logic [2:0]  nbytes;
    logic [31:0] frame_bytes;
    logic        format_ok;
    wav_result_t res;
    if (fs) clear_state();
    case (phase)
      PH_RIFF: begin
        phase_count = phase_count + 32'd1;
        if (phase_count >= RIFF_HDR_BYTES) enter_header();
      end
      PH_HDR: begin
        c3 = phase_count[2:0];
        if (c3 < 3'd4) tag = {tag[23:0], b};
        else tag_len = tag_len | ({24'd0, b} << (8 * (c3 - 3'd4)));
        phase_count = c3 + 32'd1;
        if (phase_count == 32'd8) begin
          phase_count = '0;
          if (tag == TAG_FMT) begin
            if (tag_len != 0) phase = PH_FMT;
            else enter_header();
          end else if (tag == TAG_DATA) begin
            format_ok = (fmt_bits == BITS_8 || fmt_bits == BITS_16 || fmt_bits == BITS_24 ||
                         fmt_bits == BITS_32) && fmt_chans != 16'd0;
            if (!format_ok) begin
              phase = PH_DONE;
              expected_results.push_back(make_result(KIND_ERROR, '0, '0, 1'b0));
            end else begin
              frame_bytes = {16'd0, fmt_chans} * {29'd0, fmt_bits[5:3]};
              bytes_left = (tag_len / frame_bytes) * frame_bytes;
              sample_word = '0;
              byte_pos = '0;
              chan_pos = '0;
              phase = (bytes_left != 0) ? PH_DATA : PH_DONE;
            end
          end else begin
            if (tag_len != 0) phase = PH_SKIP;
            else enter_header();
          end
        end
      end
      PH_FMT: begin
        case (phase_count)
          32'd2: fmt_chans[7:0] = b;
          32'd3: fmt_chans[15:8] = b;
          32'd4, 32'd5, 32'd6, 32'd7: fmt_rate[8 * phase_count[1:0] +: 8] = b;
          32'd14: fmt_bits[7:0] = b;
          32'd15: fmt_bits[15:8] = b;
          default: ;
        endcase
        phase_count = phase_count + 32'd1;
        if (phase_count == tag_len) enter_header();
      end
      PH_SKIP: begin
        phase_count = phase_count + 32'd1;
        if (phase_count == tag_len) enter_header();
      end
      PH_DATA: begin
        nbytes = fmt_bits[5:3];
        if (nbytes < 3'd1 || nbytes > 3'd4 || bytes_left == 0) begin
          phase = PH_DONE;
        end else begin
          sample_word = sample_word | ({24'd0, b} << (8 * byte_pos));
          bytes_left = bytes_left - 32'd1;
          if (byte_pos + 32'd1 < nbytes) begin
            byte_pos = byte_pos + 2'd1;
          end else begin
            res = make_result(KIND_SAMPLE, scale_sample(sample_word, nbytes), chan_pos,
                              bytes_left == 0);
            expected_results.push_back(res);
            chan_pos = ({1'b0, chan_pos} + 17'd1 >= {1'b0, fmt_chans}) ? 16'd0 : chan_pos + 16'd1;
            sample_word = '0;
            byte_pos = '0;
            if (res.last) phase = PH_DONE;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    wav_result_t want;
    if (rst) begin
      clear_state();
      expected_results.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: kind %0d, sample_value 0x%0h", kind,
                 sample_value);
          fails++;
        end else begin
          want = expected_results.pop_front();
          compare_field("kind", want.kind, kind);
          compare_field("sample_value", want.value, sample_value);
          compare_field("channel_index", want.ch, channel_index);
          compare_field("last_sample", want.last, last_sample);
          compare_field("channel_count", want.chans, channel_count);
          compare_field("rate_hz", want.rate, rate_hz);
          compare_field("sample_bits", want.bits, sample_bits);
          if (want.kind == KIND_ERROR) errors_seen++;
          else samples_seen++;
        end
      end
      if (byte_valid && !byte_stall) decode_byte(data_byte, file_start);
    end
    fail_count <= fails;
    pending_count <= expected_results.size();
    sample_count <= samples_seen;
    error_count <= errors_seen;
  end

endmodule

// File: dv/wav_pcm_stream_decoder_top_test.sv
module wav_pcm_stream_decoder_top_test;
  import wpsd_pkg::*;

  localparam int OUT_FRAC_BITS = 30;
  localparam int RANDOM_BYTES = 700;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 12;

  logic               clk;
  logic               rst;
  logic               byte_valid;
  logic               byte_stall;
  logic [7:0]         data_byte;
  logic               file_start;
  logic               result_valid;
  logic               result_stall;
  logic               kind;
  logic signed [31:0] sample_value;
  logic [15:0]        channel_index;
  logic               last_sample;
  logic [15:0]        channel_count;
  logic [31:0]        rate_hz;
  logic [15:0]        sample_bits;

  int fail_total;
  int pending_total;
  int sample_total;
  int error_total;

  int cycle_count = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int files_sent = 0;
  int random_start;

  logic [7:0] wav_bytes[$];

  wav_pcm_stream_decoder_top #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .file_start   (file_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .sample_value (sample_value),
    .channel_index(channel_index),
    .last_sample  (last_sample),
    .channel_count(channel_count),
    .rate_hz      (rate_hz),
    .sample_bits  (sample_bits)
  );

  wav_pcm_stream_decoder_checker #(
    .OUT_FRAC_BITS(OUT_FRAC_BITS)
  ) i_checker (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .file_start   (file_start),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .sample_value (sample_value),
    .channel_index(channel_index),
    .last_sample  (last_sample),
    .channel_count(channel_count),
    .rate_hz      (rate_hz),
    .sample_bits  (sample_bits),
    .fail_count   (fail_total),
    .pending_count(pending_total),
    .sample_count (sample_total),
    .error_count  (error_total)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("wav_pcm_stream_decoder_top_test failed");
      $finish;
    end
  end

  // The receiver cycles through no stalls, light random stalls, a fixed duty and heavy stalls.
  always @(negedge clk) begin
    case ((cycle_count / 200) % 4)
      0: result_stall <= 1'b0;
      1: result_stall <= ($urandom_range(0, 2) == 0);
      2: result_stall <= ((cycle_count % 12) < 5);
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  function automatic logic [7:0] pick_byte();
    logic [7:0] corner[6] = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'h01, 8'hFE};
    if ($urandom_range(0, 5) == 0) return corner[$urandom_range(0, 5)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_le(input logic [31:0] value, input int nbytes);
    for (int i = 0; i < nbytes; i++) wav_bytes.push_back(value[8 * i +: 8]);
  endtask

  task automatic put_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) wav_bytes.push_back(tag[8 * i +: 8]);
  endtask

  task automatic put_riff_header();
    put_tag("RIFF");
    put_le($urandom, 4);
    put_tag("WAVE");
  endtask

  task automatic put_fmt(input logic [15:0] chans, input logic [31:0] rate,
                         input logic [15:0] bits, input int len);
    logic [15:0]  align;
    logic [127:0] body;
    align = chans * bits / 16'd8;
    body = {bits, align, rate * align, rate, chans, 16'd1};
    put_tag(TAG_FMT);
    put_le(len, 4);
    for (int i = 0; i < len; i++) wav_bytes.push_back(i < 16 ? body[8 * i +: 8] : pick_byte());
  endtask

  task automatic put_chunk(input logic [31:0] tag, input int len);
    put_tag(tag);
    put_le(len, 4);
    repeat (len) wav_bytes.push_back(pick_byte());
  endtask

  task automatic put_data(input int len, input int body_len);
    put_tag(TAG_DATA);
    put_le(len, 4);
    repeat (body_len) wav_bytes.push_back(pick_byte());
  endtask

  task automatic send_byte(input logic [7:0] value, input logic first);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        byte_valid <= 1'b0;
        @(negedge clk);
      end
    end
    byte_valid <= 1'b1;
    data_byte <= value;
    file_start <= first;
    burst_left--;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_file(input int count);
    for (int i = 0; i < count; i++) send_byte(wav_bytes[i], i == 0);
    wav_bytes.delete();
    files_sent++;
  endtask

  task automatic build_random_file();
    logic [15:0] chans;
    logic [15:0] bits;
    logic [31:0] tag;
    int          fmt_len;
    int          data_len;
    if ($urandom_range(0, 15) == 0) begin
      put_le($urandom, 4);
      put_le($urandom, 4);
      put_le($urandom, 4);
      repeat ($urandom_range(8, 40)) wav_bytes.push_back(pick_byte());
    end else begin
      put_riff_header();
      if ($urandom_range(0, 15) == 0) chans = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
      else chans = 16'($urandom_range(1, 3));
      case ($urandom_range(0, 11))
        0: bits = 16'($urandom);
        1: bits = 16'(8 * $urandom_range(0, 8));
        default: bits = 16'(8 * $urandom_range(1, 4));
      endcase
      repeat ($urandom_range(0, 2)) begin
        do tag = $urandom; while (tag == TAG_FMT || tag == TAG_DATA);
        put_chunk(tag, $urandom_range(0, 5));
      end
      case ($urandom_range(0, 9))
        0: fmt_len = 0;
        1: fmt_len = $urandom_range(1, 15);
        2: fmt_len = $urandom_range(17, 22);
        default: fmt_len = 16;
      endcase
      if ($urandom_range(0, 9) != 0) put_fmt(chans, $urandom, bits, fmt_len);
      if ($urandom_range(0, 9) == 0) put_fmt(16'($urandom_range(1, 2)), $urandom, 8, 16);
      data_len = $urandom_range(0, 40);
      put_data(data_len, data_len + $urandom_range(0, 4));
    end
  endtask

  initial begin
    rst = 1'b1;
    byte_valid = 1'b0;
    data_byte = '0;
    file_start = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    put_riff_header();
    put_fmt(1, 8000, 8, 16);
    put_data(5, 0);
    put_le(32'h7FFF8000, 4);
    put_le(32'h1, 1);
    put_le($urandom, 3);
    send_file(wav_bytes.size());

    put_riff_header();
    put_chunk("junk", 0);
    put_chunk("LIST", 3);
    put_fmt(2, 44100, 16, 16);
    put_data(9, 0);
    put_le(32'h7FFF8000, 4);
    put_le(32'hFFFF0000, 4);
    put_le(32'h55, 1);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(1, 48000, 24, 18);
    put_data(9, 0);
    put_le(32'h800000, 3);
    put_le(32'h7FFFFF, 3);
    put_le(32'h1, 3);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(1, 32'hFFFFFFFF, 32, 20);
    put_data(12, 0);
    put_le(32'h80000000, 4);
    put_le(32'h7FFFFFFF, 4);
    put_le(32'hFFFFFFFF, 4);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(2, 8000, 12, 16);
    put_data(4, 4);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(0, 8000, 16, 16);
    put_data(4, 4);
    send_file(wav_bytes.size());

    put_riff_header();
    put_data(4, 4);
    send_file(wav_bytes.size());

    // A short second fmt chunk updates channels and rate but keeps the earlier width.
    put_riff_header();
    put_fmt(1, 1000, 8, 16);
    put_fmt(2, 22050, 16, 8);
    put_data(4, 0);
    put_le(32'hFF807F00, 4);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(16'hFFFF, 0, 8, 16);
    put_data(5, 5);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(1, 8000, 16, 16);
    put_data(0, 3);
    send_file(wav_bytes.size());

    put_riff_header();
    put_fmt(2, 8000, 16, 16);
    put_chunk("fact", 4);
    send_file(wav_bytes.size());

    // This file is cut off inside its data chunk by the next file.
    put_riff_header();
    put_fmt(1, 16000, 16, 16);
    put_data(20, 20);
    send_file(50);

    random_start = bytes_sent;
    while (bytes_sent - random_start < RANDOM_BYTES) begin
      build_random_file();
      if ($urandom_range(0, 9) == 0) send_file($urandom_range(1, wav_bytes.size()));
      else send_file(wav_bytes.size());
    end
    byte_valid <= 1'b0;

    @(posedge clk);
    while (pending_total != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d bytes in %0d files under random gaps and stalls.", bytes_sent,
             files_sent);
    $display("Checked %0d samples and %0d format errors.", sample_total, error_total);
    if (fail_total == 0 && pending_total == 0) begin
      $display("wav_pcm_stream_decoder_top_test passed");
    end else begin
      $display("wav_pcm_stream_decoder_top_test failed");
    end
    $finish;
  end

endmodule
